FILE: rtl/sibs_pkg.sv
// Shared types and codes for the sorted interval bound search block.
package sibs_pkg;

    localparam int POS_W  = 32;
    localparam int IDX_W  = 16;
    localparam int OUT_W  = 21;
    localparam int CNT_W  = 17;
    localparam int CFG_W  = 21;
    localparam int CFGI_W = 2;

    // Command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFGI_W-1:0] CFG_POSITION_COUNT = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_CLAMP_TO_VALID = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_INDEX_OFFSET   = 2'd2;

    typedef struct packed {
        logic                    cmd;
        logic [IDX_W-1:0]        load_index;
        logic signed [POS_W-1:0] load_position;
        logic signed [POS_W-1:0] query_start;
        logic signed [POS_W-1:0] query_stop;
    } t_in_beat;

    typedef struct packed {
        logic [OUT_W-1:0] left_index;
        logic [OUT_W-1:0] right_index;
    } t_out_beat;

endpackage

FILE: rtl/sibs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sibs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sorted_interval_bound_search.sv
// Top level of the sorted interval bound search: position RAM and probe sequencer.
// A load beat is written to the table as it is taken, and the block is ready again on the next cycle.
// A query runs two bisections, of pL and pR probes, before its result beat; pL and pR
// are each at most ceil(log2(count+1)). The single read port of the position RAM gives
// one probe per cycle. One query is in flight at a time.
// Reset clears the configuration registers and the control state; the table is not cleared.
module sorted_interval_bound_search #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [sibs_pkg::CFGI_W-1:0]     i_cfg_index,
    input  logic [sibs_pkg::CFG_W-1:0]      i_cfg_data,
    // Input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  sibs_pkg::t_in_beat              i_in_data,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output sibs_pkg::t_out_beat             o_out_data
);

    // Address width of the table, and a signed width that holds every bisection
    // bound from -1 up to TABLE_DEPTH.
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1) + 1;

    localparam logic signed [CW:0]   SPAN_ONE = (CW+1)'(1);
    localparam logic signed [CW-1:0] NEG_ONE  = '1;

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    // Configuration registers.
    logic [sibs_pkg::CNT_W-1:0] r_count;
    logic                       r_clamp;
    logic [sibs_pkg::OUT_W-1:0] r_offset;

    // Sequencer and search registers.
    logic [1:0]                      r_state, n_state;
    logic                            r_phase, n_phase;   // 0 left search, 1 right search
    logic                            r_pend, n_pend;     // a probe read is in flight
    logic signed [CW-1:0]            r_low, n_low;
    logic signed [CW-1:0]            r_high, n_high;
    logic signed [CW-1:0]            r_probe, n_probe;
    logic signed [CW-1:0]            r_cnt, n_cnt;
    logic signed [CW-1:0]            r_left, n_left;
    logic signed [CW-1:0]            r_right, n_right;
    logic signed [sibs_pkg::POS_W-1:0] r_start, n_start;
    logic signed [sibs_pkg::POS_W-1:0] r_stop, n_stop;
    logic                            r_out_valid, n_out_valid;
    sibs_pkg::t_out_beat             r_out, n_out;

    // RAM interface.
    logic                            ram_we;
    logic                            ram_re;
    logic [AW-1:0]                   ram_waddr;
    logic [AW-1:0]                   ram_raddr;
    logic signed [sibs_pkg::POS_W-1:0] ram_rdata;

    logic                            in_acc;
    logic [31:0]                     load_idx_ext;
    logic                            load_ok;
    logic signed [CW-1:0]            cnt_clamped;
    logic                            go_high;
    logic signed [CW-1:0]            nl, nh;
    logic signed [CW:0]              span;
    logic signed [CW:0]              mid_sum;
    logic signed [CW-1:0]            mid;
    logic signed [CW-1:0]            left_c, right_c;
    logic signed [31:0]              left_ext, right_ext;
    logic [31:0]                     base;
    logic [31:0]                     left_sum, right_sum;

    sibs_ram #(
        .WIDTH (sibs_pkg::POS_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_data.load_position),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The block takes a beat only while no query is in progress. A waiting result
    // does not block the input: it sits in the output register.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Loads beyond the table are dropped.
    assign load_idx_ext = {16'b0, i_in_data.load_index};
    assign load_ok      = (load_idx_ext < 32'(TABLE_DEPTH));
    assign ram_waddr    = load_idx_ext[AW-1:0];

    // A count above the table depth searches the whole table.
    always_comb begin
        if ({15'b0, r_count} > 32'(TABLE_DEPTH)) begin
            cnt_clamped = CW'(TABLE_DEPTH);
        end else begin
            cnt_clamped = CW'({15'b0, r_count});
        end
    end

    // Bisection step. When a probe read returns, the left search moves high down
    // if the entry lies above start, and the right search moves high down unless
    // the entry lies below stop. The next probe is the floor of the midpoint, and
    // it is sent straight to the RAM so that one probe completes each cycle.
    always_comb begin
        if (r_phase) begin
            go_high = !(ram_rdata < r_stop);
        end else begin
            go_high = (ram_rdata > r_start);
        end
        nl = r_low;
        nh = r_high;
        if (r_pend) begin
            if (go_high) begin
                nh = r_probe;
            end else begin
                nl = r_probe;
            end
        end
        span    = {nh[CW-1], nh} - {nl[CW-1], nl};
        mid_sum = {nl[CW-1], nl} + {nh[CW-1], nh};
        mid     = CW'(mid_sum >>> 1);
    end

    assign ram_raddr = mid[AW-1:0];

    // Clamp mode and the final offset. The sums wrap in the 21-bit result fields.
    always_comb begin
        left_c  = r_left;
        right_c = r_right;
        if (r_clamp) begin
            if (r_left < 0) begin
                left_c = '0;
            end
            if (r_right >= r_cnt) begin
                right_c = r_cnt + NEG_ONE;
            end
        end
        left_ext  = 32'(left_c);
        right_ext = 32'(right_c);
        base      = {11'b0, r_offset} + 32'd1;
        left_sum  = base + left_ext;
        right_sum = base + right_ext;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_pend      = r_pend;
        n_low       = r_low;
        n_high      = r_high;
        n_probe     = r_probe;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_right     = r_right;
        n_start     = r_start;
        n_stop      = r_stop;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.cmd == sibs_pkg::CMD_LOAD) begin
                        ram_we = load_ok;
                    end else begin
                        n_start = i_in_data.query_start;
                        n_stop  = i_in_data.query_stop;
                        n_low   = NEG_ONE;
                        n_high  = cnt_clamped;
                        n_cnt   = cnt_clamped;
                        n_pend  = 1'b0;
                        n_phase = 1'b0;
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (span > SPAN_ONE) begin
                    ram_re  = 1'b1;
                    n_probe = mid;
                    n_pend  = 1'b1;
                    n_low   = nl;
                    n_high  = nh;
                end else begin
                    n_pend = 1'b0;
                    if (!r_phase) begin
                        // The right search starts just above the left bound.
                        n_left  = nl;
                        n_low   = nl;
                        n_high  = r_cnt;
                        n_phase = 1'b1;
                    end else begin
                        n_right = nh;
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.left_index  = left_sum[sibs_pkg::OUT_W-1:0];
                    n_out.right_index = right_sum[sibs_pkg::OUT_W-1:0];
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_clamp     <= 1'b0;
            r_offset    <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sibs_pkg::CFG_POSITION_COUNT: r_count  <= i_cfg_data[sibs_pkg::CNT_W-1:0];
                    sibs_pkg::CFG_CLAMP_TO_VALID: r_clamp  <= i_cfg_data[0];
                    sibs_pkg::CFG_INDEX_OFFSET:   r_offset <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Search and result payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_low   <= n_low;
        r_high  <= n_high;
        r_probe <= n_probe;
        r_cnt   <= n_cnt;
        r_left  <= n_left;
        r_right <= n_right;
        r_start <= n_start;
        r_stop  <= n_stop;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/sibs_checker.sv
// Port-level assertions for the sorted interval bound search, with their bind.
module sibs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input sibs_pkg::t_in_beat  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall
);

    logic query_acc;
    logic load_acc;

    assign query_acc = i_in_valid && !o_in_stall && (i_in_data.cmd == sibs_pkg::CMD_QUERY);
    assign load_acc  = i_in_valid && !o_in_stall && (i_in_data.cmd == sibs_pkg::CMD_LOAD);

    // A query beat occupies the block on the following cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_acc |=> o_in_stall)
        else $error("input not stalled after a query beat");

    // A load beat completes in its own cycle.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_acc |=> !o_in_stall)
        else $error("input stalled after a load beat");

    // A new result only ever appears at the end of a query in progress.
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result beat appeared without a query in progress");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

endmodule

bind sorted_interval_bound_search sibs_checker u_sibs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);

FILE: test/tb.sv
// Self-checking testbench for the sorted interval bound search block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH      = 65536;
    localparam int RESET_CYCLES     = 10;
    // Settling time after the queues empty, long enough for one full query with margin.
    localparam int DRAIN_CYCLES     = 64;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT      = 4000;
    localparam int RANDOM_PHASES    = 20;
    localparam int PHASE_ITEMS      = 36;
    localparam int OFFSET_MAX       = (1 << sibs_pkg::OUT_W) - 1;
    localparam int COUNT_MAX        = (1 << sibs_pkg::CNT_W) - 1;

    localparam logic signed [sibs_pkg::POS_W-1:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [sibs_pkg::POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;

    // Index 3 names no register; a write there must leave every register alone.
    localparam logic [sibs_pkg::CFGI_W-1:0] CFG_NO_REGISTER = 2'd3;

    // Ways of filling the position table for one phase.
    typedef enum int {
        FILL_DENSE,      // ascending, small steps, many duplicates
        FILL_WIDE,       // ascending over most of the signed range
        FILL_SCRAMBLED,  // random order, so the bisection runs on an unsorted table
        FILL_FLAT        // every entry holds the same value
    } t_fill_kind;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [sibs_pkg::CFGI_W-1:0]   i_cfg_index = '0;
    logic [sibs_pkg::CFG_W-1:0]    i_cfg_data  = '0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    sibs_pkg::t_in_beat            i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    sibs_pkg::t_out_beat           o_out_data;

    sorted_interval_bound_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The predictor's copy of the block: the table as the accepted load beats
    // left it, and the registers as they were last written.
    logic signed [sibs_pkg::POS_W-1:0] stored_positions [TABLE_DEPTH];
    logic [sibs_pkg::CNT_W-1:0]        model_count  = '0;
    logic                              model_clamp  = 1'b0;
    logic [sibs_pkg::OUT_W-1:0]        model_offset = '0;

    // The generator's view of the table, updated when a load is queued. It is
    // only used to aim query values at stored positions.
    logic signed [sibs_pkg::POS_W-1:0] planned_positions [TABLE_DEPTH];

    sibs_pkg::t_in_beat  pending_beats[$];
    sibs_pkg::t_out_beat expected_bounds[$];

    int  mismatch_count = 0;
    bit  in_beat_taken  = 1'b0;
    int  in_gap_left    = 0;
    int  stall_left     = 0;
    int  hold_left      = 0;
    bit  hold_request   = 1'b0;
    bit  in_idling      = 1'b1;
    bit  out_idling     = 1'b1;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Two bisections over the first count entries: the left one finds the last
    // entry at or below start, the right one continues from there to the first
    // entry at or above stop. Clamp mode pulls both bounds into the table.
    function automatic sibs_pkg::t_out_beat predict_bounds(
            logic signed [sibs_pkg::POS_W-1:0] start,
            logic signed [sibs_pkg::POS_W-1:0] stop);
        int                  entries;
        int                  lo;
        int                  hi;
        int                  probe;
        int                  left;
        int                  right;
        sibs_pkg::t_out_beat bounds;
        entries = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_count);
        lo = -1;
        hi = entries;
        while (hi - lo > 1) begin
            probe = (lo + hi) / 2;
            if (stored_positions[sibs_pkg::IDX_W'(probe)] > start)
                hi = probe;
            else
                lo = probe;
        end
        left = lo;
        hi = entries;
        while (hi - lo > 1) begin
            probe = (lo + hi) / 2;
            if (stored_positions[sibs_pkg::IDX_W'(probe)] < stop)
                lo = probe;
            else
                hi = probe;
        end
        right = hi;
        if (model_clamp) begin
            if (left < 0)
                left = 0;
            if (right >= entries)
                right = entries - 1;
        end
        // The sums wrap at the output width.
        bounds.left_index  = sibs_pkg::OUT_W'(int'(model_offset) + 1 + left);
        bounds.right_index = sibs_pkg::OUT_W'(int'(model_offset) + 1 + right);
        return bounds;
    endfunction

    // Query values land mostly on or next to stored positions, where the
    // comparisons flip; the rest are random or at the ends of the range.
    function automatic logic signed [sibs_pkg::POS_W-1:0] pick_value(int n);
        int r;
        r = $urandom_range(0, 99);
        if (n == 0 || r < 15)
            return $urandom;
        if (r < 65)
            return planned_positions[sibs_pkg::IDX_W'($urandom_range(0, n - 1))]
                   + $urandom_range(0, 2) - 1;
        if (r < 80)
            return $urandom_range(0, 1) ? planned_positions[0] - 1
                                        : planned_positions[sibs_pkg::IDX_W'(n - 1)] + 1;
        return $urandom_range(0, 1) ? POS_MIN : POS_MAX;
    endfunction

    // Fields that a beat ignores carry random values.
    task automatic push_load(int idx, logic signed [sibs_pkg::POS_W-1:0] pos);
        sibs_pkg::t_in_beat b;
        b.cmd           = sibs_pkg::CMD_LOAD;
        b.load_index    = sibs_pkg::IDX_W'(idx);
        b.load_position = pos;
        b.query_start   = $urandom;
        b.query_stop    = $urandom;
        pending_beats.push_back(b);
        planned_positions[sibs_pkg::IDX_W'(idx)] = pos;
    endtask

    task automatic push_query(logic signed [sibs_pkg::POS_W-1:0] start,
                              logic signed [sibs_pkg::POS_W-1:0] stop);
        sibs_pkg::t_in_beat b;
        b.cmd           = sibs_pkg::CMD_QUERY;
        b.load_index    = sibs_pkg::IDX_W'($urandom);
        b.load_position = $urandom;
        b.query_start   = start;
        b.query_stop    = stop;
        pending_beats.push_back(b);
    endtask

    // Queries at the ends of the range, whose bisections only walk the
    // outermost probe paths of the table.
    task automatic push_end_queries();
        push_query(POS_MIN, POS_MIN);
        push_query(POS_MIN, POS_MAX);
        push_query(POS_MAX, POS_MAX);
        push_query(POS_MAX, POS_MIN);
    endtask

    // Writes one register and updates the predictor's copy. Only called while
    // the block is idle, so the predictor may change at once.
    task automatic write_reg(logic [sibs_pkg::CFGI_W-1:0] index,
                             logic [sibs_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        case (index)
            sibs_pkg::CFG_POSITION_COUNT: model_count  = data[sibs_pkg::CNT_W-1:0];
            sibs_pkg::CFG_CLAMP_TO_VALID: model_clamp  = data[0];
            sibs_pkg::CFG_INDEX_OFFSET:   model_offset = data[sibs_pkg::OUT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every queued beat went in and every result came out, then
    // lets a trailing load finish inside the block. Checked at the rising edge
    // only, where the queue and the valid are both settled.
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pending_beats.size() != 0 || i_in_valid || expected_bounds.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One phase: new register settings, optionally a freshly filled table of
    // exactly count entries, then a mix of queries and stray loads.
    task automatic run_phase(int count_value, bit clamp, int offset_value, bit refill,
                             t_fill_kind kind, int n_items, bit gaps_in, bit gaps_out);
        int                                n;
        int                                idx;
        int unsigned                       step_max;
        longint                            v;
        logic signed [sibs_pkg::POS_W-1:0] pos;
        logic signed [sibs_pkg::POS_W-1:0] flat_value;
        logic signed [sibs_pkg::POS_W-1:0] start;
        logic signed [sibs_pkg::POS_W-1:0] stop;
        logic [sibs_pkg::CFG_W-1:0]        cfg_word;
        wait_idle();
        in_idling  = gaps_in;
        out_idling = gaps_out;
        n = (count_value > TABLE_DEPTH) ? TABLE_DEPTH : count_value;

        // Bits above each register's width are random: the block must drop them.
        cfg_word = sibs_pkg::CFG_W'($urandom);
        cfg_word[sibs_pkg::CNT_W-1:0] = sibs_pkg::CNT_W'(count_value);
        write_reg(sibs_pkg::CFG_POSITION_COUNT, cfg_word);
        cfg_word = sibs_pkg::CFG_W'($urandom);
        cfg_word[0] = clamp;
        write_reg(sibs_pkg::CFG_CLAMP_TO_VALID, cfg_word);
        write_reg(sibs_pkg::CFG_INDEX_OFFSET, sibs_pkg::CFG_W'(offset_value));

        if (refill) begin
            flat_value = $urandom;
            step_max   = (n > 0) ? 32'hFFFF_FFFF / n : 0;
            if (kind == FILL_WIDE)
                v = $urandom_range(0, 1) ? longint'(POS_MIN)
                                         : longint'(POS_MIN) + $urandom_range(0, 1 << 20);
            else
                v = longint'($urandom_range(0, 2000)) - 1000;
            for (idx = 0; idx < n; idx++) begin
                case (kind)
                    FILL_DENSE: begin
                        pos = v[sibs_pkg::POS_W-1:0];
                        v += $urandom_range(0, 3);
                    end
                    FILL_WIDE: begin
                        pos = v[sibs_pkg::POS_W-1:0];
                        v += $urandom_range(0, step_max);
                        if (v > longint'(POS_MAX))
                            v = POS_MAX;
                        if (idx == n - 1 && $urandom_range(0, 1))
                            pos = POS_MAX;
                    end
                    FILL_SCRAMBLED: pos = $urandom;
                    default:        pos = flat_value;
                endcase
                push_load(idx, pos);
            end
        end

        // Mostly queries; the stray loads may land inside the table and break
        // its order, which the bisection must still follow.
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 85) begin
                start = pick_value(n);
                case ($urandom_range(0, 3))
                    0, 1:    stop = start + $urandom_range(0, 40);
                    2:       stop = pick_value(n);
                    default: stop = $urandom;
                endcase
                push_query(start, stop);
            end else begin
                push_load($urandom_range(0, n + 15) % TABLE_DEPTH, $urandom);
            end
        end
    endtask

    // Acceptance of an input beat: loads go into the predictor's table and
    // queries leave their expected bounds behind. Sampled before the block's
    // own updates at this edge take effect.
    always @(posedge i_clk) begin
        in_beat_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_beat_taken) begin
            if (i_in_data.cmd == sibs_pkg::CMD_LOAD)
                stored_positions[i_in_data.load_index] = i_in_data.load_position;
            else
                expected_bounds.push_back(predict_bounds(i_in_data.query_start,
                                                         i_in_data.query_stop));
        end
    end

    // Driver: offers the next pending beat at the falling edge, after a random
    // gap. A beat that was not taken stays on the bus unchanged, and valid is
    // assigned once per edge so a back-to-back beat keeps it high.
    always @(negedge i_clk) begin : drive_input
        logic offer;
        offer = i_in_valid && !in_beat_taken;
        if (i_rst_n && !offer) begin
            if (in_gap_left > 0) begin
                in_gap_left--;
            end else if (pending_beats.size() != 0) begin
                i_in_data   <= pending_beats.pop_front();
                offer       = 1'b1;
                in_gap_left = in_idling ? pick_gap() : 0;
            end
        end
        i_in_valid <= offer;
    end

    // Receiver: random stalls, plus one long hold when asked for, so that a
    // finished result sits in the block while the driver keeps offering beats.
    always @(negedge i_clk) begin
        if (hold_request && hold_left == 0) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = out_idling ? pick_gap() : 0;
        end
    end

    // Monitor: every result beat is matched against the oldest expectation.
    always @(posedge i_clk) begin : check_result
        sibs_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bounds.size() == 0) begin
                mismatch_count++;
                $display("%0t: expected no result beat, actual left_index %0d right_index %0d",
                         $time, o_out_data.left_index, o_out_data.right_index);
            end else begin
                want = expected_bounds.pop_front();
                if (o_out_data.left_index !== want.left_index) begin
                    mismatch_count++;
                    $display("%0t: left_index mismatch: expected %0d, actual %0d",
                             $time, want.left_index, o_out_data.left_index);
                end
                if (o_out_data.right_index !== want.right_index) begin
                    mismatch_count++;
                    $display("%0t: right_index mismatch: expected %0d, actual %0d",
                             $time, want.right_index, o_out_data.right_index);
                end
            end
        end
    end

    // Watchdog: a run that stops moving beats, on either side and without
    // register writes, is a hang.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
                    || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("** sorted_interval_bound_search: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int         p;
        int         r;
        int         k;
        int         count_value;
        int         offset_value;
        bit         clamp;
        t_fill_kind kind;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table straight out of reset: bounds are -1 and 0.
        push_query(POS_MIN, POS_MAX);
        push_query(POS_MAX, POS_MIN);
        wait_idle();

        // Empty table with clamp: the bounds cross, 0 and -1. The write to the
        // unused index must not disturb anything.
        write_reg(sibs_pkg::CFG_CLAMP_TO_VALID, sibs_pkg::CFG_W'(1));
        write_reg(CFG_NO_REGISTER, sibs_pkg::CFG_W'($urandom));
        push_query(0, 0);
        wait_idle();

        // Small table reaching both ends of the range, with a duplicate pair.
        write_reg(sibs_pkg::CFG_POSITION_COUNT, sibs_pkg::CFG_W'(5));
        write_reg(sibs_pkg::CFG_CLAMP_TO_VALID, sibs_pkg::CFG_W'(0));
        write_reg(sibs_pkg::CFG_INDEX_OFFSET, sibs_pkg::CFG_W'(100));
        push_load(0, POS_MIN);
        push_load(1, -5);
        push_load(2, 0);
        push_load(3, 0);
        push_load(4, POS_MAX);
        push_query(POS_MIN, POS_MIN);
        push_query(-6, -5);
        push_query(0, 0);
        push_query(POS_MAX, POS_MAX);
        push_query(1, 2);
        push_query(0, -5);
        wait_idle();

        // Same table with clamp and the largest offset, so the sums wrap. The
        // receiver holds off for a long stretch here, so that one result waits
        // in the block, the next query finishes behind it and the input stalls.
        write_reg(sibs_pkg::CFG_CLAMP_TO_VALID, sibs_pkg::CFG_W'(1));
        write_reg(sibs_pkg::CFG_INDEX_OFFSET, sibs_pkg::CFG_W'(OFFSET_MAX));
        hold_request = 1'b1;
        push_query(POS_MIN, POS_MAX);
        push_query(POS_MAX, POS_MAX);
        push_query(-5, 0);
        push_query(POS_MAX, POS_MIN);

        // Random phases, mostly small tables so that each fill stays short.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                count_value = 1;
            else if (r < 20)
                count_value = 2;
            else if (r < 65)
                count_value = $urandom_range(3, 32);
            else if (r < 92)
                count_value = $urandom_range(33, 128);
            else
                count_value = $urandom_range(129, 256);
            r = $urandom_range(0, 99);
            if (r < 15)
                offset_value = OFFSET_MAX - $urandom_range(0, 200);
            else if (r < 25)
                offset_value = 0;
            else
                offset_value = $urandom_range(0, OFFSET_MAX);
            r = $urandom_range(0, 99);
            if (r < 35)
                kind = FILL_DENSE;
            else if (r < 70)
                kind = FILL_WIDE;
            else if (r < 85)
                kind = FILL_SCRAMBLED;
            else
                kind = FILL_FLAT;
            clamp = 1'($urandom_range(0, 1));
            // Each side runs with no gaps in one phase in five, chosen independently.
            run_phase(count_value, clamp, offset_value, 1'b1, kind, PHASE_ITEMS,
                      $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
        end

        // Counts at and beyond the depth must search the whole table. Only the
        // entries on the two outermost probe paths are loaded, each holding its
        // own index, and every query lies at an end of the range, so the
        // bisections never touch any other entry.
        wait_idle();
        offset_value = $urandom_range(0, OFFSET_MAX);
        write_reg(sibs_pkg::CFG_POSITION_COUNT, sibs_pkg::CFG_W'(TABLE_DEPTH));
        write_reg(sibs_pkg::CFG_CLAMP_TO_VALID, sibs_pkg::CFG_W'(0));
        write_reg(sibs_pkg::CFG_INDEX_OFFSET, sibs_pkg::CFG_W'(offset_value));
        for (k = 0; k < sibs_pkg::IDX_W; k++) begin
            push_load((1 << k) - 1, (1 << k) - 1);
            push_load(TABLE_DEPTH - 1 - (1 << k), TABLE_DEPTH - 1 - (1 << k));
        end
        push_load(TABLE_DEPTH - 1, TABLE_DEPTH - 1);
        push_end_queries();
        wait_idle();

        write_reg(sibs_pkg::CFG_POSITION_COUNT, sibs_pkg::CFG_W'(COUNT_MAX));
        write_reg(sibs_pkg::CFG_CLAMP_TO_VALID, sibs_pkg::CFG_W'(1));
        write_reg(sibs_pkg::CFG_INDEX_OFFSET, sibs_pkg::CFG_W'(0));
        push_end_queries();
        wait_idle();

        write_reg(sibs_pkg::CFG_POSITION_COUNT, sibs_pkg::CFG_W'(TABLE_DEPTH + 1));
        write_reg(sibs_pkg::CFG_CLAMP_TO_VALID, sibs_pkg::CFG_W'(0));
        write_reg(sibs_pkg::CFG_INDEX_OFFSET, sibs_pkg::CFG_W'(OFFSET_MAX));
        push_end_queries();

        wait_idle();
        if (mismatch_count == 0)
            $display("** sorted_interval_bound_search: PASSED **");
        else
            $display("** sorted_interval_bound_search: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sibs_pkg.sv
rtl/sibs_ram.sv
rtl/sorted_interval_bound_search.sv
rtl/sibs_checker.sv
test/tb.sv
